[rtl/apf_pkg.sv]
package apf_pkg;

    // Operation codes carried in the request word
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_SILENCE = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    // Register indexes on the configuration channel
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BYTES = 2'd0,
        CFG_EIGHT_BIT   = 2'd1,
        CFG_ENABLE      = 2'd2
    } cfg_idx_t;

    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned PEND_W       = 17;
    localparam int unsigned LIMIT_W      = LEN_W + 3;   // five bursts
    localparam int unsigned FRAME_RESET  = 4408;
    localparam logic [BYTE_W-1:0] SILENCE_U8  = 8'h80;
    localparam logic [BYTE_W-1:0] SILENCE_ZERO = 8'h00;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] write_byte;
        logic              first_of_chunk;
        logic [LEN_W-1:0]  chunk_bytes;
    } req_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              accepted;
        logic              dropped;
        logic [PEND_W-1:0] pending_bytes;
    } rsp_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_word_t;

endpackage

[rtl/apf_if.sv]
interface apf_req_if;
    import apf_pkg::*;
    logic      valid;
    logic      ready;
    req_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface apf_rsp_if;
    import apf_pkg::*;
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface apf_cfg_if;
    import apf_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/apf_ram.sv]
module apf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/audio_playout_fifo.sv]
// Byte-wide playout ring buffer for PCM audio.
//
// req : one word per operation - write a data byte, insert a silence byte,
//       read a byte for the output device, or restart.
// rsp : exactly one word per request, in order: the byte read (zero when
//       none), read/accept/drop flags and the pending count after the step.
// cfg : register writes (0 frame_bytes, 1 eight_bit_samples,
//       2 engine_enable), always ready; the user must write them only
//       while the block is idle, which the block does not enforce.
// Timing: the response word of an accepted request is loaded into the
// output register at the accepting edge, and the block sustains one word
// per cycle while rsp is taken. The limit is the single read port of the
// sample RAM, whose registered data feeds rsp. All pointer and count
// updates are made at acceptance; the RAM read is issued at the same
// edge, so the stored byte reaches rsp along with the response word.
// If rsp stalls the response word holds and req is held off until it goes.
// Reset clears pointers, count, budget and rsp valid; config gets defaults;
// the sample RAM is not cleared (nothing is read before it is written).
module audio_playout_fifo #(
    parameter int unsigned BUF_BYTES = 65536
) (
    input  logic clk,
    input  logic rst_n,
    apf_req_if.sink   req,
    apf_rsp_if.source rsp,
    apf_cfg_if.sink   cfg
);
    import apf_pkg::*;

    localparam int unsigned PTR_W = $clog2(BUF_BYTES);
    localparam int unsigned CNT_W = $clog2(BUF_BYTES + 1);
    localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Pointers, fill count and chunk budget
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] keep_reg, keep_next;

    // Configuration
    logic [LEN_W-1:0] frame_reg;
    logic             eight_bit_reg;
    logic             enable_reg;

    // Response register (payload held apart from the RAM data register)
    logic             out_valid_reg;
    logic             meta_rvalid_reg, meta_rvalid_next;
    logic             meta_acc_reg, meta_acc_next;
    logic             meta_drop_reg, meta_drop_next;
    logic [CNT_W-1:0] meta_count_reg;

    logic             take;
    logic             store;
    logic             fetch;
    logic [BYTE_W-1:0] store_byte;
    logic [BYTE_W-1:0] ram_rdata;
    logic             full;
    logic             empty;
    logic             trim;
    logic [CMP_W-1:0] cmp_count;
    logic [CMP_W-1:0] cmp_limit;
    logic [LIMIT_W-1:0] limit;
    logic [LEN_W-1:0] budget;
    logic [CNT_W+PEND_W-1:0] pend_ext;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign full  = (count_reg == CNT_W'(BUF_BYTES));
    assign empty = (count_reg == '0);

    // Catch-up test: pending count above five playback bursts
    assign limit     = (LIMIT_W'(frame_reg) << 2) + LIMIT_W'(frame_reg);
    assign cmp_count = CMP_W'(count_reg);
    assign cmp_limit = CMP_W'(limit);
    assign trim      = cmp_count > cmp_limit;

    always_comb
    begin
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        count_next       = count_reg;
        keep_next        = keep_reg;
        meta_rvalid_next = 1'b0;
        meta_acc_next    = 1'b0;
        meta_drop_next   = 1'b0;
        store            = 1'b0;
        fetch            = 1'b0;
        store_byte       = req.data.write_byte;
        budget           = keep_reg;

        unique case (op_t'(req.data.operation))
            OP_WRITE:
            begin
                if (!enable_reg)
                begin
                    meta_drop_next = 1'b1;
                end
                else
                begin
                    if (req.data.first_of_chunk)
                    begin
                        budget = trim ? (req.data.chunk_bytes >> 1) : req.data.chunk_bytes;
                    end
                    if (budget == '0)
                    begin
                        keep_next      = '0;
                        meta_drop_next = 1'b1;
                    end
                    else
                    begin
                        keep_next = budget - LEN_W'(1);
                        if (full)
                        begin
                            meta_drop_next = 1'b1;
                        end
                        else
                        begin
                            store         = 1'b1;
                            meta_acc_next = 1'b1;
                        end
                    end
                end
            end
            OP_SILENCE:
            begin
                store_byte = eight_bit_reg ? SILENCE_U8 : SILENCE_ZERO;
                if (enable_reg && !full)
                begin
                    store         = 1'b1;
                    meta_acc_next = 1'b1;
                end
            end
            OP_READ:
            begin
                if (!empty)
                begin
                    fetch            = 1'b1;
                    meta_rvalid_next = 1'b1;
                    rd_ptr_next      = (rd_ptr_reg == PTR_W'(BUF_BYTES - 1))
                                       ? '0 : rd_ptr_reg + PTR_W'(1);
                    count_next       = count_reg - CNT_W'(1);
                end
            end
            OP_RESTART:
            begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                count_next  = '0;
                keep_next   = '0;
            end
            default:
            begin
                keep_next = keep_reg;
            end
        endcase

        if (store)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(BUF_BYTES - 1))
                          ? '0 : wr_ptr_reg + PTR_W'(1);
            count_next  = count_reg + CNT_W'(1);
        end
    end

    apf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (take && store),
        .waddr (wr_ptr_reg),
        .wdata (store_byte),
        .re    (take && fetch),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                count_reg  <= count_next;
                keep_reg   <= keep_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            meta_rvalid_reg <= meta_rvalid_next;
            meta_acc_reg    <= meta_acc_next;
            meta_drop_reg   <= meta_drop_next;
            meta_count_reg  <= count_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= LEN_W'(FRAME_RESET);
            eight_bit_reg <= 1'b0;
            enable_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_FRAME_BYTES: frame_reg     <= cfg.data.data;
                CFG_EIGHT_BIT:   eight_bit_reg <= cfg.data.data[0];
                CFG_ENABLE:      enable_reg    <= cfg.data.data[0];
                default:         frame_reg     <= frame_reg;
            endcase
        end
    end

    assign pend_ext = {{PEND_W{1'b0}}, meta_count_reg};

    assign rsp.valid              = out_valid_reg;
    assign rsp.data.read_byte     = meta_rvalid_reg ? ram_rdata : '0;
    assign rsp.data.read_valid    = meta_rvalid_reg;
    assign rsp.data.accepted      = meta_acc_reg;
    assign rsp.data.dropped       = meta_drop_reg;
    assign rsp.data.pending_bytes = pend_ext[PEND_W-1:0];

endmodule

[verif/playout_checker.sv]
`timescale 1ns / 100ps

module playout_checker
    import apf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    apf_req_if          req,
    apf_rsp_if          rsp,
    apf_cfg_if          cfg,
    output int unsigned fail_count,
    output int unsigned words_due
);

    localparam int unsigned RING_BYTES = 65536;

    // Local copy of the playout buffer; 16-bit pointers wrap at RING_BYTES
    logic [BYTE_W-1:0]     ring [RING_BYTES];
    logic [LEN_W-1:0]      wr_ptr;
    logic [LEN_W-1:0]      rd_ptr;
    logic [PEND_W-1:0]     fill;
    logic [LEN_W-1:0]      budget;
    logic [CFG_DATA_W-1:0] burst_bytes;
    logic                  u8_silence;
    logic                  enabled;
    rsp_word_t             rsp_due [$];

    function automatic logic push_byte(input logic [BYTE_W-1:0] b);
        if (fill == PEND_W'(RING_BYTES))
            return 1'b0;
        ring[wr_ptr] = b;
        wr_ptr       = wr_ptr + 1'b1;
        fill         = fill + 1'b1;
        return 1'b1;
    endfunction

    task automatic predict_response(input req_word_t w, output rsp_word_t r);
        int unsigned catch_up_level;
        r = '0;
        case (w.operation)
            OP_WRITE:
            begin
                if (!enabled)
                    r.dropped = 1'b1;
                else
                begin
                    if (w.first_of_chunk)
                    begin
                        catch_up_level = 5 * burst_bytes;
                        budget = (fill > catch_up_level) ? (w.chunk_bytes >> 1) : w.chunk_bytes;
                    end
                    if (budget == '0)
                        r.dropped = 1'b1;
                    else
                    begin
                        budget = budget - 1'b1;
                        if (push_byte(w.write_byte))
                            r.accepted = 1'b1;
                        else
                            r.dropped = 1'b1;
                    end
                end
            end
            OP_SILENCE:
            begin
                if (enabled && push_byte(u8_silence ? SILENCE_U8 : SILENCE_ZERO))
                    r.accepted = 1'b1;
            end
            OP_READ:
            begin
                if (fill != '0)
                begin
                    r.read_byte  = ring[rd_ptr];
                    r.read_valid = 1'b1;
                    rd_ptr       = rd_ptr + 1'b1;
                    fill         = fill - 1'b1;
                end
            end
            default:
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                fill   = '0;
                budget = '0;
            end
        endcase
        r.pending_bytes = fill;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_word_t want;
        rsp_word_t got;
        logic      bad;
        if (!rst_n)
        begin
            wr_ptr      = '0;
            rd_ptr      = '0;
            fill        = '0;
            budget      = '0;
            burst_bytes = CFG_DATA_W'(FRAME_RESET);
            u8_silence  = 1'b0;
            enabled     = 1'b0;
            rsp_due.delete();
            fail_count  = 0;
            words_due  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    CFG_FRAME_BYTES: burst_bytes = cfg.data.data;
                    CFG_EIGHT_BIT:   u8_silence  = cfg.data.data[0];
                    CFG_ENABLE:      enabled     = cfg.data.data[0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                predict_response(req.data, want);
                rsp_due.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (rsp_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: response word with none due: byte %h rv %b acc %b drop %b pend %0d",
                                 $time, got.read_byte, got.read_valid, got.accepted,
                                 got.dropped, got.pending_bytes);
                    fail_count++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    bad  = (got.read_byte     !== want.read_byte)  ||
                           (got.read_valid    !== want.read_valid) ||
                           (got.accepted      !== want.accepted)   ||
                           (got.dropped       !== want.dropped)    ||
                           (got.pending_bytes !== want.pending_bytes);
                    if (bad)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch, exp byte %h rv %b acc %b drop %b pend %0d",
                                     $time, want.read_byte, want.read_valid, want.accepted,
                                     want.dropped, want.pending_bytes);
                            $display("%0t:           got byte %h rv %b acc %b drop %b pend %0d",
                                     $time, got.read_byte, got.read_valid, got.accepted,
                                     got.dropped, got.pending_bytes);
                        end
                        fail_count++;
                    end
                end
            end
            words_due <= rsp_due.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import apf_pkg::*;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned words_due;

    // idle percentages for the two sides, changed per phase
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned words_sent = 0;

    apf_req_if req_if ();
    apf_rsp_if rsp_if ();
    apf_cfg_if cfg_if ();

    audio_playout_fifo dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    playout_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .cfg        (cfg_if),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Response side: ready drops at random with the current stall rate
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Guard against a hang; well over ten times the slowest legal run
    initial
    begin
        #15_000_000;
        $display("audio_playout_fifo regression: fail");
        $finish;
    end

    // One request word. Valid stays high into the next call when no gap is
    // drawn, so back-to-back words go at one per cycle while req is ready.
    task automatic send_op(input op_t op, input logic [BYTE_W-1:0] b,
                           input logic first, input logic [LEN_W-1:0] len);
        req_word_t w;
        w.operation      = op;
        w.write_byte     = b;
        w.first_of_chunk = first;
        w.chunk_bytes    = len;
        while ($urandom_range(99) < gap_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        do @(posedge clk); while (!req_if.ready);
        words_sent++;
    endtask

    // Fields that the operation ignores carry random noise
    task automatic send_noisy(input op_t op);
        send_op(op, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
    endtask

    // Hold off the sender until every response word has come back
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_word_t c;
        c.index = idx;
        c.data  = val;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= c;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random phase: mostly well-formed chunks (first byte carries the
    // length, then data bytes, some past the budget) mixed with read
    // bursts, silence, restarts and the odd stray write.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] frame, input logic eight,
                             input logic en, input int unsigned gap, input int unsigned stall,
                             input int unsigned n_words);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        int unsigned nbytes;
        bit          held;
        settle();
        set_reg(CFG_FRAME_BYTES, frame);
        set_reg(CFG_EIGHT_BIT, CFG_DATA_W'(eight));
        set_reg(CFG_ENABLE, CFG_DATA_W'(en));
        gap_pct   = gap;
        stall_pct = stall;
        start     = words_sent;
        held      = 1'b0;
        while (words_sent - start < n_words)
        begin
            // one full drain mid-phase
            if (!held && words_sent - start >= n_words / 2)
            begin
                held = 1'b1;
                settle();
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len    = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 24);
                nbytes = $urandom_range(1, 30);
                send_op(OP_WRITE, BYTE_W'($urandom), 1'b1, LEN_W'(len));
                repeat (nbytes - 1)
                begin
                    if ($urandom_range(99) < 30)
                        send_noisy(OP_READ);
                    if ($urandom_range(99) < 5)
                        send_noisy(OP_SILENCE);
                    send_op(OP_WRITE, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
                end
            end
            else if (pick < 85)
                repeat ($urandom_range(1, 12)) send_noisy(OP_READ);
            else if (pick < 95)
                repeat ($urandom_range(1, 4)) send_noisy(OP_SILENCE);
            else if (pick < 98)
                send_noisy(OP_RESTART);
            else
                send_noisy(OP_WRITE);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, engine off. Data is dropped, silence
        // ignored, a read of the empty buffer underruns, restart is clean.
        send_op(OP_WRITE, 8'hFF, 1'b1, 16'hFFFF);
        send_op(OP_SILENCE, 8'h00, 1'b0, 16'h0000);
        send_op(OP_READ, 8'h00, 1'b0, 16'h0000);
        send_op(OP_RESTART, 8'hFF, 1'b1, 16'hFFFF);

        // One byte per burst so that catch-up starts at six pending bytes
        settle();
        set_reg(CFG_FRAME_BYTES, 16'd1);
        set_reg(CFG_EIGHT_BIT, 16'd1);
        set_reg(CFG_ENABLE, 16'd1);
        send_op(OP_SILENCE, 8'h00, 1'b0, 16'h0000);    // unsigned silence
        send_op(OP_WRITE, 8'h00, 1'b1, 16'd3);         // full budget of three
        send_op(OP_WRITE, 8'hFF, 1'b0, 16'h0000);
        send_op(OP_WRITE, 8'hA5, 1'b0, 16'h0000);
        send_op(OP_WRITE, 8'h5A, 1'b0, 16'h0000);      // budget used up
        send_op(OP_SILENCE, 8'h00, 1'b0, 16'h0000);
        send_op(OP_SILENCE, 8'h00, 1'b0, 16'h0000);    // six pending now
        send_op(OP_WRITE, 8'h3C, 1'b1, 16'd7);         // trimmed to three
        send_op(OP_WRITE, 8'hC3, 1'b0, 16'h0000);
        send_op(OP_WRITE, 8'h0F, 1'b0, 16'h0000);
        send_op(OP_WRITE, 8'hF0, 1'b0, 16'h0000);      // past trimmed budget
        send_op(OP_WRITE, 8'h11, 1'b1, 16'd1);         // half of one is nothing
        send_op(OP_WRITE, 8'h22, 1'b1, 16'd0);         // zero-length chunk
        send_op(OP_READ, 8'h00, 1'b0, 16'h0000);
        send_op(OP_READ, 8'h00, 1'b0, 16'h0000);
        send_op(OP_READ, 8'h00, 1'b0, 16'h0000);

        settle();
        set_reg(CFG_EIGHT_BIT, 16'd0);
        send_op(OP_SILENCE, 8'hFF, 1'b1, 16'hFFFF);    // zero silence
        send_op(OP_RESTART, 8'h00, 1'b0, 16'h0000);
        send_op(OP_READ, 8'h00, 1'b0, 16'h0000);

        // Random phases across the idling patterns and several settings
        run_phase(16'd1, 1'b1, 1'b1, 0, 0, 180);
        run_phase(16'd3, 1'b0, 1'b1, 52, 0, 180);
        run_phase(16'hFFFF, 1'b1, 1'b1, 0, 52, 180);
        run_phase(CFG_DATA_W'($urandom_range(1, 6)), 1'b0, 1'b1, 18, 18, 180);
        run_phase(16'd2, 1'b1, 1'b0, 18, 18, 50);

        settle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("audio_playout_fifo regression: pass");
        else
            $display("audio_playout_fifo regression: fail");
        $finish;
    end

endmodule
